[rtl/core/thbd_pkg.sv]
// ----------------------------------------------------------------------------
// thbd_pkg
// Shared types and constants of the table Huffman bit decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thbd_pkg;

  localparam int unsigned OFF_W  = 16;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned BIT_W  = 4;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [OFF_W-1:0] LEAF_FLAG = 16'h8000;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] table_addr;
    logic [7:0]        table_byte;
    logic [15:0]       code_word;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       done_res;
    logic       bad_node;
  } out_res_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

endpackage

[rtl/core/thbd_node_mem.sv]
// ----------------------------------------------------------------------------
// thbd_node_mem
// Node table split in even and odd byte banks, so that one 16-bit entry at
// any byte offset is read in a single access; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thbd_node_mem #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic                      clk_i,
  input  thbd_pkg::tbl_wr_t         wr_i,
  input  logic [thbd_pkg::OFF_W-1:0] rd_off_i,
  output logic [thbd_pkg::OFF_W-1:0] rd_entry_o
);
  import thbd_pkg::*;

  localparam int unsigned EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int unsigned ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int unsigned EW = $clog2(EVEN_DEPTH);
  localparam int unsigned OW = $clog2(ODD_DEPTH);

  logic [7:0] even_mem [EVEN_DEPTH];
  logic [7:0] odd_mem  [ODD_DEPTH];

  logic [OFF_W:0]  even_sum;
  logic [EW-1:0]   even_rd_idx;
  logic [OW-1:0]   odd_rd_idx;
  logic [EW-1:0]   even_wr_idx;
  logic [OW-1:0]   odd_wr_idx;
  logic [7:0]      even_q;
  logic [7:0]      odd_q;
  logic            par_q;

  // entry at offset o: low byte at o, high byte at o+1
  assign even_sum    = {1'b0, rd_off_i} + {{OFF_W{1'b0}}, 1'b1};
  assign even_rd_idx = EW'(even_sum[OFF_W:1]);
  assign odd_rd_idx  = OW'(rd_off_i[OFF_W-1:1]);
  assign even_wr_idx = EW'(wr_i.addr[ADDR_W-1:1]);
  assign odd_wr_idx  = OW'(wr_i.addr[ADDR_W-1:1]);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      even_mem[even_wr_idx] <= wr_i.data;
    end
    even_q <= even_mem[even_rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.addr[0]) begin
      odd_mem[odd_wr_idx] <= wr_i.data;
    end
    odd_q <= odd_mem[odd_rd_idx];
  end

  always_ff @(posedge clk_i) begin
    par_q <= rd_off_i[0];
  end

  assign rd_entry_o = par_q ? {even_q, odd_q} : {odd_q, even_q};

endmodule

[rtl/core/thbd_walker.sv]
// ----------------------------------------------------------------------------
// thbd_walker
// Tree walk sequencer: one code bit per cycle unless stalled; next address
// from the entry just read; results pass a hold stage to mark the last one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thbd_walker #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  thbd_pkg::in_req_t          in_req_i,
  input  logic [thbd_pkg::LEN_W-1:0] out_len_i,
  input  logic                       out_free_i,
  output logic                       push_o,
  output thbd_pkg::out_res_t         push_res_o,
  output thbd_pkg::tbl_wr_t          wr_o,
  output logic [thbd_pkg::OFF_W-1:0] rd_off_o,
  input  logic [thbd_pkg::OFF_W-1:0] rd_entry_i
);
  import thbd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam logic [OFF_W:0] TBL_LIMIT = (OFF_W + 1)'(TABLE_BYTES);

  logic [1:0]       state_q, state_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [OFF_W-1:0] pend_q, pend_d;
  logic [BIT_W-1:0] idx_q, idx_d;
  logic [15:0]      word_q, word_d;
  logic [LEN_W-1:0] bytes_q, bytes_d;
  logic             halted_q, halted_d;
  logic             hold_valid_q, hold_valid_d;
  out_res_t         hold_q, hold_d;

  logic [OFF_W-1:0] o_issue, o_run, base;
  logic             bad_issue, bad_run, leaf, can_produce, done_new;
  logic [BIT_W-1:0] next_idx;
  logic [LEN_W-1:0] bytes_inc;
  out_res_t         res_new;

  always_comb begin
    o_issue   = off_q + {{(OFF_W-2){1'b0}}, word_q[idx_q], 1'b0};
    bad_issue = ({1'b0, o_issue} + {{OFF_W{1'b0}}, 1'b1}) >= TBL_LIMIT;
    leaf      = (rd_entry_i & LEAF_FLAG) != '0;
    base      = leaf ? '0 : rd_entry_i;
    next_idx  = idx_q - {{(BIT_W-1){1'b0}}, 1'b1};
    o_run     = base + {{(OFF_W-2){1'b0}}, word_q[next_idx], 1'b0};
    bad_run   = ({1'b0, o_run} + {{OFF_W{1'b0}}, 1'b1}) >= TBL_LIMIT;
    bytes_inc = bytes_q + {{(LEN_W-1){1'b0}}, 1'b1};
    done_new  = bytes_inc >= out_len_i;
    // a new result moves the held one out first
    can_produce = !hold_valid_q || out_free_i;
  end

  always_comb begin
    state_d      = state_q;
    off_d        = off_q;
    pend_d       = pend_q;
    idx_d        = idx_q;
    word_d       = word_q;
    bytes_d      = bytes_q;
    halted_d     = halted_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    in_ready_o   = 1'b0;
    push_o       = 1'b0;
    push_res_o   = hold_q;
    push_res_o.last = 1'b0;
    wr_o         = '0;
    rd_off_o     = pend_q;
    res_new      = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_req_i.mode)
            MODE_LOAD: begin
              wr_o.en   = ({{(OFF_W+1-ADDR_W){1'b0}}, in_req_i.table_addr} < TBL_LIMIT);
              wr_o.addr = in_req_i.table_addr;
              wr_o.data = in_req_i.table_byte;
            end
            MODE_START: begin
              off_d    = '0;
              bytes_d  = '0;
              halted_d = 1'b0;
            end
            MODE_WORD: begin
              if (!halted_q && (bytes_q < out_len_i)) begin
                word_d  = in_req_i.code_word;
                idx_d   = '1;
                state_d = S_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_ISSUE: begin
        if (bad_issue) begin
          if (can_produce) begin
            push_o           = hold_valid_q;
            res_new.bad_node = 1'b1;
            hold_d           = res_new;
            hold_valid_d     = 1'b1;
            halted_d         = 1'b1;
            off_d            = o_issue;
            state_d          = S_FLUSH;
          end
        end else begin
          rd_off_o = o_issue;
          pend_d   = o_issue;
          state_d  = S_RUN;
        end
      end

      S_RUN: begin
        if (leaf && !can_produce) begin
          // output full: read the same entry again and wait
          rd_off_o = pend_q;
        end else begin
          off_d = base;
          if (leaf) begin
            push_o           = hold_valid_q;
            res_new.out_byte = rd_entry_i[7:0];
            res_new.done_res = done_new;
            hold_d           = res_new;
            hold_valid_d     = 1'b1;
            bytes_d          = bytes_inc;
          end
          if ((leaf && done_new) || (idx_q == '0)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = next_idx;
            if (bad_run) begin
              state_d = S_ISSUE;
            end else begin
              rd_off_o = o_run;
              pend_d   = o_run;
            end
          end
        end
      end

      S_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          push_o          = 1'b1;
          push_res_o.last = 1'b1;
          hold_valid_d    = 1'b0;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      off_q        <= '0;
      bytes_q      <= '0;
      halted_q     <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      off_q        <= off_d;
      bytes_q      <= bytes_d;
      halted_q     <= halted_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    idx_q  <= idx_d;
    word_q <= word_d;
    hold_q <= hold_d;
  end

endmodule

[rtl/core/table_huffman_bit_decoder_unit.sv]
// ----------------------------------------------------------------------------
// table_huffman_bit_decoder_unit
// Huffman stream decoder walking a byte-addressed table of 16-bit nodes.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------
//   in      | in        | in_valid_i / in_ready_o    | in_req_i (in_req_t)
//   out     | out       | out_valid_o / out_ready_i  | out_res_o (out_res_t)
//   cfg     | in        | cfg_we_i                   | cfg_wdata_i
//
// loads, stream starts and skipped words are handled without leaving the idle state
// a code word is accepted, issues its first node read, walks its bits in turn
// and flushes the held result; the walk is paced by the table read loop
// (entry read -> next node address)
// a node address outside the table found mid-walk goes back through the issue state
// a full output register stalls the walk; no reset of the node table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_huffman_bit_decoder_unit #(
  parameter int unsigned TABLE_BYTES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  thbd_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output thbd_pkg::out_res_t         out_res_o,
  input  logic                       cfg_we_i,
  input  logic [thbd_pkg::LEN_W-1:0] cfg_wdata_i
);
  import thbd_pkg::*;

  logic [LEN_W-1:0] len_q;
  logic             out_valid_q, out_valid_d;
  out_res_t         out_q, out_d;
  logic             out_free;
  logic             push;
  out_res_t         push_res;
  tbl_wr_t          tbl_wr;
  logic [OFF_W-1:0] rd_off;
  logic [OFF_W-1:0] rd_entry;

  assign out_free = !out_valid_q || out_ready_i;

  thbd_walker #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_len_i  (len_q),
    .out_free_i (out_free),
    .push_o     (push),
    .push_res_o (push_res),
    .wr_o       (tbl_wr),
    .rd_off_o   (rd_off),
    .rd_entry_i (rd_entry)
  );

  thbd_node_mem #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_node_mem (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_off_i   (rd_off),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // a halting result ends its word and carries no symbol
  a_bad_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.bad_node |->
      out_res_o.last && !out_res_o.done_res && (out_res_o.out_byte == '0))
    else $error("bad node result malformed");

  // reaching the length ends the word
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> out_res_o.last)
    else $error("done result not marked last");

  // a request is never taken while a result is being pushed out
  a_no_accept_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !in_ready_o)
    else $error("request accepted during result push");

  // a push never overwrites a result that is still waiting
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed into full output register");

endmodule

[test/tb_table_huffman_bit_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_table_huffman_bit_decoder_unit
// Self-checking bench for the table Huffman bit decoder. A hand-built tree
// and random trees are planted in the node table and walked with code words
// under several output lengths. A clocked driver feeds requests from a
// queue, a clocked monitor checks every decoded result against a tree
// walker kept in the bench, and both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_table_huffman_bit_decoder_unit;

  import thbd_pkg::*;

  localparam int          TABLE_BYTES = 1024;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [LEN_W-1:0] LEN_MAX = 31'h7FFF_FFFF;
  localparam int          SETTLE_CYC  = 40;
  localparam int          HOLD_CYC    = 400;
  localparam int          RAND_ITEMS  = 370;
  localparam longint      LIMIT_NS    = 64'd10_000_000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_req_t          in_req_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_res_t         out_res_o;
  logic             cfg_we_i    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;

  table_huffman_bit_decoder_unit #(
    .TABLE_BYTES(TABLE_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // walker state, mirrors the decoder
  logic [7:0]       node_mem [TABLE_BYTES];
  logic [OFF_W-1:0] walk_off = '0;
  logic [LEN_W-1:0] emitted  = '0;
  logic             stopped  = 1'b0;
  logic [LEN_W-1:0] len_cfg  = '0;

  in_req_t  req_q[$];
  out_res_t decoded_q[$];

  int unsigned in_idle_pct  = 16;
  int unsigned out_idle_pct = 16;
  bit          hold_go      = 1'b0;
  bit          hold_done    = 1'b0;
  int          hold_left    = 0;

  int queued_cnt = 0;
  int req_cnt    = 0;
  int sym_cnt    = 0;
  int bad_cnt    = 0;
  int done_cnt   = 0;
  int cfg_cnt    = 0;
  int err_cnt    = 0;

  initial begin
    for (int i = 0; i < TABLE_BYTES; i++) node_mem[i] = '0;
  end

  // walk one accepted request and queue the symbols it decodes
  task automatic walk_tree(input in_req_t req);
    out_res_t         syms [16];
    int               n;
    int               b;
    bit               stop;
    logic [OFF_W-1:0] entry;
    n    = 0;
    stop = 1'b0;
    case (req.mode)
      MODE_LOAD: begin
        if (int'(req.table_addr) < TABLE_BYTES) node_mem[req.table_addr] = req.table_byte;
      end
      MODE_START: begin
        walk_off = '0;
        emitted  = '0;
        stopped  = 1'b0;
      end
      MODE_WORD: begin
        if (!stopped && emitted < len_cfg) begin
          for (b = 15; b >= 0 && !stop; b--) begin
            if (req.code_word[b]) walk_off = walk_off + 16'd2;
            if (int'(walk_off) >= TABLE_BYTES - 1) begin
              stopped           = 1'b1;
              syms[n]           = '0;
              syms[n].bad_node  = 1'b1;
              n++;
              stop = 1'b1;
            end else begin
              entry = {node_mem[int'(walk_off) + 1], node_mem[walk_off]};
              if ((entry & LEAF_FLAG) == '0) begin
                walk_off = entry;
              end else begin
                walk_off         = '0;
                emitted          = emitted + LEN_W'(1);
                syms[n]          = '0;
                syms[n].out_byte = entry[7:0];
                syms[n].done_res = (emitted >= len_cfg);
                stop             = syms[n].done_res;
                n++;
              end
            end
          end
          if (n > 0) syms[n-1].last = 1'b1;
          for (b = 0; b < n; b++) decoded_q.push_back(syms[b]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_res_t got);
    out_res_t want;
    if (decoded_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: byte %02h last %0b done %0b bad %0b",
                 got.out_byte, got.last, got.done_res, got.bad_node);
    end else begin
      want = decoded_q.pop_front();
      if (want.bad_node) bad_cnt++;
      else sym_cnt++;
      if (want.done_res) done_cnt++;
      if (got.out_byte !== want.out_byte || got.last !== want.last ||
          got.done_res !== want.done_res || got.bad_node !== want.bad_node) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: byte %02h/%02h last %0b/%0b done %0b/%0b bad %0b/%0b (exp/got)",
                   want.out_byte, got.out_byte, want.last, got.last,
                   want.done_res, got.done_res, want.bad_node, got.bad_node);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        walk_tree(in_req_i);
        req_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_req_i   <= req_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor, with a one-time long hold-off of the output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_res_o);
      if (hold_go && !hold_done) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYC;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic queue_req(input logic [1:0] mode, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] data, input logic [15:0] word);
    in_req_t r;
    r.mode       = mode;
    r.table_addr = addr;
    r.table_byte = data;
    r.code_word  = word;
    req_q.push_back(r);
    queued_cnt++;
  endtask

  task automatic push_load(input int addr, input logic [7:0] data);
    queue_req(MODE_LOAD, ADDR_W'(addr), data, 16'($urandom));
  endtask

  task automatic push_word(input logic [15:0] word);
    queue_req(MODE_WORD, ADDR_W'($urandom), 8'($urandom), word);
  endtask

  task automatic push_start();
    queue_req(MODE_START, ADDR_W'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic push_entry(input int addr, input logic [15:0] entry);
    push_load(addr, entry[7:0]);
    push_load(addr + 1, entry[15:8]);
  endtask

  // random tree of node pairs at 4-byte steps from offset 0
  task automatic plant_tree(input int pairs);
    int          slots[$];
    int          idx;
    int          slot;
    int          next_pair;
    logic [15:0] entry;
    slots     = '{0, 2};
    next_pair = 1;
    while (slots.size() != 0) begin
      idx  = $urandom_range(slots.size() - 1);
      slot = slots[idx];
      slots.delete(idx);
      if (next_pair < pairs && $urandom_range(2) != 0) begin
        entry = 16'(4 * next_pair);
        slots.push_back(4 * next_pair);
        slots.push_back(4 * next_pair + 2);
        next_pair++;
      end else if ($urandom_range(15) == 0) begin
        // pointer to a node that runs past the table end
        entry = 16'($urandom_range(16'h7FFF, TABLE_BYTES - 1));
      end else begin
        entry = {1'b1, 7'($urandom), 8'($urandom)};
      end
      push_entry(slot, entry);
    end
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    len_cfg = len;
    cfg_cnt++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender pauses until every predicted result is back, then lets the walk settle
  task automatic drain_results();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  initial begin
    int          k;
    int          n;
    int          phase;
    int          rand_start;
    int unsigned pick;
    logic [15:0] word;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_length(LEN_MAX);

    // hand-built tree: self loop at 12, pointer to the table end at 10
    push_entry(0, 16'h8000);
    push_entry(2, 16'd4);
    push_entry(4, 16'hFFFF);
    push_entry(6, 16'd8);
    push_entry(8, 16'd12);
    push_entry(10, 16'd1022);
    push_entry(12, 16'd12);
    push_entry(14, 16'h8081);
    push_entry(1022, 16'h80A5);
    push_start();
    push_word(16'h0000);                 // sixteen symbols
    push_word(16'hAAAA);
    push_word(16'h0001);                 // walk left pending across words
    push_word(16'h0000);
    push_word(16'hC000);                 // stuck in the loop, nothing out
    push_word(16'h8000);
    push_word(16'hE000);                 // last valid entry of the table
    push_word(16'hF000);                 // runs off the table end
    push_word(16'h0000);                 // halted, ignored
    queue_req(MODE_UNUSED, '1, '1, '1);
    push_start();
    push_entry(12, 16'd1023);
    push_word(16'hC000);
    push_start();
    push_entry(12, 16'h7FFF);
    push_word(16'hC000);
    drain_results();

    set_length(LEN_W'(3));
    push_start();
    push_word(16'h0000);                 // stops at the third symbol
    push_word(16'h0000);
    push_start();
    push_word(16'hAAAA);
    drain_results();

    set_length('0);
    push_start();
    push_word(16'h0000);
    drain_results();

    set_length(LEN_W'(1));
    push_start();
    push_word(16'hFFFF);
    push_word(16'h0000);
    drain_results();

    rand_start = queued_cnt;
    phase      = 0;
    while (queued_cnt - rand_start < RAND_ITEMS || phase < 4) begin
      case (phase % 6)
        0: set_length(LEN_W'($urandom_range(6, 1)));
        1: set_length(LEN_MAX);
        2: set_length(LEN_W'($urandom_range(40, 7)));
        3: set_length(LEN_W'($urandom_range(3, 1)));
        4: set_length(LEN_W'($urandom));
        default: set_length(LEN_W'($urandom_range(100, 10)));
      endcase
      plant_tree(phase == 2 ? 20 : $urandom_range(8, 1));
      push_start();
      if (phase == 1) begin
        // no idling, and the receiver holds off while requests pile up
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_go      = 1'b1;
      end
      n = $urandom_range(40, 30);
      for (k = 0; k < n; k++) begin
        if (phase == 3 && k == n / 2) drain_results();
        pick = $urandom_range(99);
        if (pick < 76) begin
          if ($urandom_range(9) == 0) word = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else word = 16'($urandom);
          push_word(word);
        end else if (pick < 86) begin
          push_start();
        end else if (pick < 96) begin
          // a set leaf flag on a high byte keeps every walk on planted nodes
          if ($urandom_range(1) != 0)
            push_load(2 * $urandom_range(127) + 1, {1'b1, 7'($urandom)});
          else
            push_load($urandom_range(TABLE_BYTES - 3, 256), 8'($urandom));
        end else begin
          queue_req(MODE_UNUSED, ADDR_W'($urandom), 8'($urandom), 16'($urandom));
        end
      end
      drain_results();
      in_idle_pct  = 16;
      out_idle_pct = 16;
      phase++;
    end

    $display("covered %0d requests: %0d symbols, %0d bad-node halts, %0d length stops",
             req_cnt, sym_cnt, bad_cnt, done_cnt);
    $display("%0d output length settings from zero to full range, one %0d-cycle hold-off",
             cfg_cnt, HOLD_CYC);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
